/* rtl/core/zzrr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package zzrr_pkg;

  localparam int unsigned MAX_LEN  = 64;
  localparam int unsigned MAX_ROWS = 16;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ADDR_W = $clog2(MAX_LEN);
  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned RAIL_W = $clog2(MAX_ROWS);
  localparam int unsigned ROWS_W = 5;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_START = 3'b010,
    ST_EMIT  = 3'b100
  } zzrr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;  // write the accepted word into the rail lists
    logic first;  // fetch the head of the lowest occupied rail
    logic walk;   // step along the current rail or on to the next one
    logic clear;  // drop the message state after the final word
  } zzrr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_tail;     // current word is the last one of its rail
    logic more_rails;  // an occupied rail follows the current one
  } zzrr_stat_t;

endpackage

`default_nettype wire

/* rtl/core/zigzag_rail_reorder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         start / busy               in_char_i, in_last_i
// result    out        out_strobe_o (no stall)    out_char_o, out_last_o, overflow_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_data_i (num_rows)
//
// A word is taken whenever start is high while busy is low; busy stays low between message words.
// A word with in_last_i set starts the readout: a setup state (ST_START), then one
// result word per cycle over the stored rail lists.
// Reset clears the message state; the byte and link memories need no clearing.
// The receiver cannot stall; results appear on consecutive cycles.
module zigzag_rail_reorder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [zzrr_pkg::CHAR_W-1:0] in_char_i,
  input  wire logic                        in_last_i,
  output logic                             out_strobe_o,
  output logic [zzrr_pkg::CHAR_W-1:0]      out_char_o,
  output logic                             out_last_o,
  output logic                             overflow_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [zzrr_pkg::ROWS_W-1:0] cfg_data_i
);

  zzrr_pkg::zzrr_cmd_t  cmd;
  zzrr_pkg::zzrr_stat_t stat;

  assign cfg_ready_o = 1'b1;

  zzrr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .in_last_i    (in_last_i),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .busy         (busy),
    .out_strobe_o (out_strobe_o),
    .out_last_o   (out_last_o)
  );

  zzrr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_char_i   (in_char_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_char_o  (out_char_o),
    .overflow_o  (overflow_o)
  );

endmodule

`default_nettype wire

/* rtl/core/zzrr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module zzrr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic               in_last_i,
  input  wire zzrr_pkg::zzrr_stat_t stat_i,
  output zzrr_pkg::zzrr_cmd_t     cmd_o,
  output logic                    busy,
  output logic                    out_strobe_o,
  output logic                    out_last_o
);

  zzrr_pkg::zzrr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= zzrr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    busy         = 1'b1;
    out_strobe_o = 1'b0;
    out_last_o   = 1'b0;
    case (state_q)
      zzrr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.store = 1'b1;
          if (in_last_i) begin
            state_d = zzrr_pkg::ST_START;
          end
        end
      end
      zzrr_pkg::ST_START: begin
        cmd_o.first = 1'b1;
        state_d     = zzrr_pkg::ST_EMIT;
      end
      zzrr_pkg::ST_EMIT: begin
        out_strobe_o = 1'b1;
        cmd_o.walk   = 1'b1;
        if (stat_i.at_tail && !stat_i.more_rails) begin
          out_last_o  = 1'b1;
          cmd_o.clear = 1'b1;
          state_d     = zzrr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = zzrr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/zzrr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module zzrr_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [zzrr_pkg::ROWS_W-1:0]   cfg_data_i,
  input  wire logic [zzrr_pkg::CHAR_W-1:0]   in_char_i,
  input  wire zzrr_pkg::zzrr_cmd_t           cmd_i,
  output zzrr_pkg::zzrr_stat_t               stat_o,
  output logic [zzrr_pkg::CHAR_W-1:0]        out_char_o,
  output logic                               overflow_o
);

  localparam int unsigned AW = zzrr_pkg::ADDR_W;
  localparam int unsigned CW = zzrr_pkg::CNT_W;
  localparam int unsigned RW = zzrr_pkg::RAIL_W;
  localparam int unsigned NW = zzrr_pkg::ROWS_W;
  localparam int unsigned NR = zzrr_pkg::MAX_ROWS;

  // Lowest occupied rail at or above from_idx.
  function automatic logic [RW:0] find_rail(input logic [NR-1:0] valid,
                                            input logic [NW-1:0] from_idx);
    logic [RW:0] res;
    res = '0;
    for (int i = NR - 1; i >= 0; i--) begin
      if (valid[i] && (NW'(i) >= from_idx)) begin
        res = {1'b1, RW'(i)};
      end
    end
    return res;
  endfunction

  logic [NW-1:0]               num_rows_q;
  logic [CW-1:0]               fill_q;
  logic [RW-1:0]               rail_pos_q;
  logic                        moving_up_q;
  logic                        ovf_q;
  logic [NR-1:0]               rail_valid_q;
  logic [AW-1:0]               head_q [NR];
  logic [AW-1:0]               tail_q [NR];
  logic [zzrr_pkg::CHAR_W-1:0] byte_mem [zzrr_pkg::MAX_LEN];
  logic [AW-1:0]               next_mem [zzrr_pkg::MAX_LEN];
  logic [zzrr_pkg::CHAR_W-1:0] rd_byte_q;
  logic [AW-1:0]               rd_next_q;
  logic [AW-1:0]               cur_q;
  logic [RW-1:0]               rail_q;

  logic [NW-1:0] rows;
  logic [RW-1:0] top;
  logic [RW-1:0] pos;
  logic [RW-1:0] pos_d;
  logic          up_d;
  logic          has_room;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] tail_sel;
  logic [AW-1:0] tail_rd;
  logic [NW-1:0] search_from;
  logic [RW:0]   found;
  logic [AW-1:0] head_rd;
  logic          at_tail;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= NW'(1);
    end else if (cfg_valid_i) begin
      num_rows_q <= cfg_data_i;
    end
  end

  // Rail count in use: zero acts as one, large values saturate.
  always_comb begin
    if (num_rows_q == '0) begin
      rows = NW'(1);
    end else if (num_rows_q > NW'(NR)) begin
      rows = NW'(NR);
    end else begin
      rows = num_rows_q;
    end
    top = RW'(rows - NW'(1));
    pos = (rail_pos_q > top) ? top : rail_pos_q;
    pos_d = pos;
    up_d  = moving_up_q;
    if (top == '0) begin
      pos_d = '0;
      up_d  = 1'b0;
    end else if (!moving_up_q) begin
      if (pos >= top) begin
        up_d  = 1'b1;
        pos_d = top - RW'(1);
      end else begin
        pos_d = pos + RW'(1);
      end
    end else begin
      if (pos == '0) begin
        up_d  = 1'b0;
        pos_d = RW'(1);
      end else begin
        pos_d = pos - RW'(1);
      end
    end
  end

  assign has_room = (fill_q < CW'(zzrr_pkg::MAX_LEN));
  assign wr_addr  = fill_q[AW-1:0];

  assign tail_sel    = cmd_i.store ? pos : rail_q;
  assign tail_rd     = tail_q[tail_sel];
  assign at_tail     = (cur_q == tail_rd);
  assign search_from = cmd_i.first ? '0 : (NW'(rail_q) + NW'(1));
  assign found       = find_rail(rail_valid_q, search_from);
  assign head_rd     = head_q[found[RW-1:0]];

  assign stat_o.at_tail    = at_tail;
  assign stat_o.more_rails = found[RW];

  // Each rail is a linked list through next_mem; walking it reads one word a cycle.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_rd;
    if (cmd_i.first) begin
      rd_en = 1'b1;
    end else if (cmd_i.walk) begin
      if (!at_tail) begin
        rd_en   = 1'b1;
        rd_addr = rd_next_q;
      end else if (found[RW]) begin
        rd_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      rail_pos_q   <= '0;
      moving_up_q  <= 1'b0;
      ovf_q        <= 1'b0;
      rail_valid_q <= '0;
    end else if (cmd_i.clear) begin
      fill_q       <= '0;
      rail_pos_q   <= '0;
      moving_up_q  <= 1'b0;
      ovf_q        <= 1'b0;
      rail_valid_q <= '0;
    end else if (cmd_i.store) begin
      if (has_room) begin
        fill_q            <= fill_q + CW'(1);
        rail_pos_q        <= pos_d;
        moving_up_q       <= up_d;
        rail_valid_q[pos] <= 1'b1;
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && has_room) begin
      byte_mem[wr_addr] <= in_char_i;
      if (rail_valid_q[pos]) begin
        next_mem[tail_rd] <= wr_addr;
      end else begin
        head_q[pos] <= wr_addr;
      end
      tail_q[pos] <= wr_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_byte_q <= byte_mem[rd_addr];
      rd_next_q <= next_mem[rd_addr];
      cur_q     <= rd_addr;
    end
    if (rd_en && (cmd_i.first || at_tail)) begin
      rail_q <= found[RW-1:0];
    end
  end

  assign out_char_o = rd_byte_q;
  assign overflow_o = ovf_q;

endmodule

`default_nettype wire
